>>> rtl/owpr_pkg.sv
// Package: shared types, constants and CRC helpers for the page reader.
`timescale 1ns / 1ps
package owpr_pkg;
    localparam int PAGE_BYTES     = 32;
    localparam int MAX_PAGES      = 64;
    localparam int REDIRECT_LIMIT = 16;
    localparam int OFF_W          = $clog2(PAGE_BYTES);
    localparam int PAGE_W         = 6;
    localparam int STORE_DEPTH    = MAX_PAGES * PAGE_BYTES;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    localparam logic [7:0]  CMD_READ_CRC8 = 8'hC3;
    localparam logic [7:0]  CMD_EXT_READ  = 8'hA5;
    localparam logic [15:0] CRC16_RESIDUE = 16'hB001;
    localparam logic [7:0]  NO_REDIRECT   = 8'hFF;

    localparam logic [1:0] REQ_FETCH  = 2'd0;
    localparam logic [1:0] REQ_SELECT = 2'd1;
    localparam logic [1:0] REQ_BYTE   = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [2:0] K_SELECT  = 3'd0;
    localparam logic [2:0] K_TX      = 3'd1;
    localparam logic [2:0] K_READY   = 3'd2;
    localparam logic [2:0] K_FAILED  = 3'd3;
    localparam logic [2:0] K_BYTE    = 3'd4;
    localparam logic [2:0] K_REFUSED = 3'd5;

    localparam logic CFG_CRC_MODE     = 1'b0;
    localparam logic CFG_MEMORY_PAGES = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAIT_SELECT, PH_CMD_CRC8, PH_DATA8, PH_DATA_CRC8,
        PH_REDIR, PH_DATA16, PH_DATA_CRC16
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [5:0] page;
        logic       last;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction
endpackage

>>> rtl/onewire_eprom_page_reader.sv
// Top level: one-wire page read sequencer with page cache and result queue.
// Timing: a fetch, select or byte result is registered into the result queue on acceptance;
// a cached byte read goes through the page store's registered read, then into its queue slot.
// Throughput: one input word per cycle while the result queue has room; a successful select
// outcome produces three result words, which drain at one per cycle while m_ready is high.
// Reset: aresetn (synchronous) clears phase, valid map, counters and queue; the page store
// is not cleared and its read data is queued only for valid pages.
`timescale 1ns / 1ps
module onewire_eprom_page_reader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [5:0]  s_page_number,
    input  logic        s_select_ok,
    input  logic [7:0]  s_bus_byte,
    input  logic [10:0] s_byte_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [5:0]  m_out_page,
    output logic        m_last
);
    localparam int QD = 4;

    logic                            crc_mode_reg;
    logic [6:0]                      memory_pages_reg;
    logic [owpr_pkg::MAX_PAGES-1:0]  valid_reg, valid_next;
    owpr_pkg::phase_t                phase_reg, phase_next;
    logic [5:0]                      count_reg, count_next;
    logic [7:0]                      crc8_reg, crc8_next;
    logic [15:0]                     crc16_reg, crc16_next;
    logic [4:0]                      retries_reg, retries_next;
    logic [5:0]                      target_reg, target_next;
    logic [7:0]                      addr_page_reg, addr_page_next;
    logic [7:0]                      redir_reg, redir_next;

    owpr_pkg::result_t               q_reg [QD];
    logic [1:0]                      rd_ptr_reg, wr_ptr_reg;
    logic [2:0]                      fill_reg;
    // cached read pending: the result comes from the RAM the next cycle
    logic                            rd_pend_reg;
    logic [1:0]                      rd_slot_reg;

    logic              accept;
    logic [1:0]        n_push;
    owpr_pkg::result_t push0, push1, push2;
    logic              ram_we;
    logic [10:0]       ram_waddr;
    logic [7:0]        ram_rdata;
    logic              rd_ok;
    logic [7:0]        t1, t2, cmd;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign pop       = m_valid && m_ready;
    // room for three results; a pending RAM read holds its slot already
    assign s_ready   = (fill_reg <= 3'(QD - 3)) || (pop && fill_reg == 3'(QD - 2));
    assign accept    = s_valid && s_ready;

    owpr_ram #(.WIDTH(8), .DEPTH(owpr_pkg::STORE_DEPTH)) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_bus_byte),
        .raddr(s_byte_offset),
        .rdata(ram_rdata)
    );

    // byte address of the page is page * 32: low byte, then high byte
    assign t1  = {addr_page_reg[2:0], 5'd0};
    assign t2  = {3'd0, addr_page_reg[7:3]};
    assign cmd = crc_mode_reg ? owpr_pkg::CMD_EXT_READ : owpr_pkg::CMD_READ_CRC8;
    assign ram_waddr = {target_reg, count_reg[4:0]};
    assign rd_ok = ({1'b0, s_byte_offset} < {memory_pages_reg, 5'd0}) &&
                   valid_reg[s_byte_offset[10:5]];

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        crc8_next      = crc8_reg;
        crc16_next     = crc16_reg;
        retries_next   = retries_reg;
        target_next    = target_reg;
        addr_page_next = addr_page_reg;
        redir_next     = redir_reg;
        valid_next     = valid_reg;
        n_push = 2'd0;
        push0  = '{kind: owpr_pkg::K_FAILED, data: 8'd0, page: target_reg, last: 1'b1};
        push1  = '{kind: owpr_pkg::K_TX, data: t1, page: 6'd0, last: 1'b0};
        push2  = '{kind: owpr_pkg::K_TX, data: t2, page: 6'd0, last: 1'b1};
        ram_we = 1'b0;
        if (accept) begin
            case (s_req_type)
                owpr_pkg::REQ_FETCH: begin
                    if (phase_reg == owpr_pkg::PH_IDLE) begin
                        target_next = s_page_number;
                        n_push = 2'd1;
                        if ({1'b0, s_page_number} >= memory_pages_reg) begin
                            push0 = '{owpr_pkg::K_FAILED, 8'd0, s_page_number, 1'b1};
                        end else if (valid_reg[s_page_number]) begin
                            push0 = '{owpr_pkg::K_READY, 8'd0, s_page_number, 1'b1};
                        end else begin
                            addr_page_next = {2'd0, s_page_number};
                            retries_next   = 5'(owpr_pkg::REDIRECT_LIMIT);
                            phase_next     = owpr_pkg::PH_WAIT_SELECT;
                            push0 = '{owpr_pkg::K_SELECT, 8'd0, 6'd0, 1'b1};
                        end
                    end
                end
                owpr_pkg::REQ_SELECT: begin
                    if (phase_reg == owpr_pkg::PH_WAIT_SELECT) begin
                        if (!s_select_ok) begin
                            n_push = 2'd1;
                            phase_next = owpr_pkg::PH_IDLE;
                        end else begin
                            n_push = 2'd3;
                            push0 = '{owpr_pkg::K_TX, cmd, 6'd0, 1'b0};
                            count_next = 6'd0;
                            if (crc_mode_reg) begin
                                crc16_next = owpr_pkg::crc16_byte(owpr_pkg::crc16_byte(
                                    owpr_pkg::crc16_byte(16'd0, cmd), t1), t2);
                                phase_next = owpr_pkg::PH_REDIR;
                            end else begin
                                crc8_next = owpr_pkg::crc8_byte(owpr_pkg::crc8_byte(
                                    owpr_pkg::crc8_byte(8'd0, cmd), t1), t2);
                                phase_next = owpr_pkg::PH_CMD_CRC8;
                            end
                        end
                    end
                end
                owpr_pkg::REQ_READ: begin
                    n_push = 2'd1;
                end
                default: begin
                    case (phase_reg)
                        owpr_pkg::PH_CMD_CRC8: begin
                            if (s_bus_byte != crc8_reg) begin
                                n_push = 2'd1;
                                phase_next = owpr_pkg::PH_IDLE;
                            end else begin
                                crc8_next  = 8'd0;
                                count_next = 6'd0;
                                phase_next = owpr_pkg::PH_DATA8;
                            end
                        end
                        owpr_pkg::PH_DATA8, owpr_pkg::PH_DATA16: begin
                            ram_we = 1'b1;
                            if (phase_reg == owpr_pkg::PH_DATA8)
                                crc8_next = owpr_pkg::crc8_byte(crc8_reg, s_bus_byte);
                            else
                                crc16_next = owpr_pkg::crc16_byte(crc16_reg, s_bus_byte);
                            count_next = count_reg + 6'd1;
                            if (count_reg == 6'(owpr_pkg::PAGE_BYTES - 1)) begin
                                if (phase_reg == owpr_pkg::PH_DATA8) begin
                                    phase_next = owpr_pkg::PH_DATA_CRC8;
                                end else begin
                                    count_next = 6'd0;
                                    phase_next = owpr_pkg::PH_DATA_CRC16;
                                end
                            end
                        end
                        owpr_pkg::PH_DATA_CRC8: begin
                            n_push = 2'd1;
                            phase_next = owpr_pkg::PH_IDLE;
                            if (s_bus_byte == crc8_reg) begin
                                push0.kind = owpr_pkg::K_READY;
                                valid_next[target_reg] = 1'b1;
                            end
                        end
                        owpr_pkg::PH_REDIR: begin
                            if (count_reg == 6'd0) redir_next = s_bus_byte;
                            crc16_next = owpr_pkg::crc16_byte(crc16_reg, s_bus_byte);
                            count_next = count_reg + 6'd1;
                            if (count_reg == 6'd2) begin
                                if (crc16_next != owpr_pkg::CRC16_RESIDUE) begin
                                    n_push = 2'd1;
                                    phase_next = owpr_pkg::PH_IDLE;
                                end else if (redir_reg != owpr_pkg::NO_REDIRECT) begin
                                    n_push = 2'd1;
                                    if (retries_reg == 5'd0) begin
                                        phase_next = owpr_pkg::PH_IDLE;
                                    end else begin
                                        retries_next   = retries_reg - 5'd1;
                                        addr_page_next = redir_reg ^ 8'hFF;
                                        phase_next     = owpr_pkg::PH_WAIT_SELECT;
                                        push0 = '{owpr_pkg::K_SELECT, 8'd0, 6'd0, 1'b1};
                                    end
                                end else begin
                                    crc16_next = 16'd0;
                                    count_next = 6'd0;
                                    phase_next = owpr_pkg::PH_DATA16;
                                end
                            end
                        end
                        owpr_pkg::PH_DATA_CRC16: begin
                            crc16_next = owpr_pkg::crc16_byte(crc16_reg, s_bus_byte);
                            count_next = count_reg + 6'd1;
                            if (count_reg == 6'd1) begin
                                n_push = 2'd1;
                                phase_next = owpr_pkg::PH_IDLE;
                                if (crc16_next == owpr_pkg::CRC16_RESIDUE) begin
                                    push0.kind = owpr_pkg::K_READY;
                                    valid_next[target_reg] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_mode_reg     <= 1'b1;
            memory_pages_reg <= 7'd64;
            valid_reg        <= '0;
            phase_reg        <= owpr_pkg::PH_IDLE;
            count_reg        <= '0;
            crc8_reg         <= '0;
            crc16_reg        <= '0;
            retries_reg      <= 5'(owpr_pkg::REDIRECT_LIMIT);
            target_reg       <= '0;
            addr_page_reg    <= '0;
            redir_reg        <= owpr_pkg::NO_REDIRECT;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            rd_pend_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == owpr_pkg::CFG_CRC_MODE) crc_mode_reg <= cfg_data[0];
                else memory_pages_reg <= cfg_data;
            end
            valid_reg     <= valid_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            crc8_reg      <= crc8_next;
            crc16_reg     <= crc16_next;
            retries_reg   <= retries_next;
            target_reg    <= target_next;
            addr_page_reg <= addr_page_next;
            redir_reg     <= redir_next;
            rd_pend_reg   <= accept && s_req_type == owpr_pkg::REQ_READ && rd_ok;
            wr_ptr_reg    <= wr_ptr_reg + n_push;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            fill_reg <= fill_reg + {1'b0, n_push} - {2'd0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            if (s_req_type == owpr_pkg::REQ_READ)
                q_reg[wr_ptr_reg] <= '{owpr_pkg::K_REFUSED, 8'd0, 6'd0, 1'b1};
            else
                q_reg[wr_ptr_reg] <= push0;
        end
        if (n_push == 2'd3) begin
            q_reg[wr_ptr_reg + 2'd1] <= push1;
            q_reg[wr_ptr_reg + 2'd2] <= push2;
        end
        rd_slot_reg <= wr_ptr_reg;
        // fill a pending read's slot once the RAM data is out
        if (rd_pend_reg)
            q_reg[rd_slot_reg] <= '{owpr_pkg::K_BYTE, ram_rdata, 6'd0, 1'b1};
    end

    // a pending read's slot must not be shown before it is filled
    assign m_valid    = (fill_reg != 3'd0) && !(rd_pend_reg && rd_slot_reg == rd_ptr_reg);
    assign m_out_kind = q_reg[rd_ptr_reg].kind;
    assign m_out_byte = q_reg[rd_ptr_reg].data;
    assign m_out_page = q_reg[rd_ptr_reg].page;
    assign m_last     = q_reg[rd_ptr_reg].last;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'(QD)) else $error("result queue overflow");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> fill_reg != 3'd0) else $error("pop from empty queue");
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (phase_reg == owpr_pkg::PH_DATA8 || phase_reg == owpr_pkg::PH_DATA16))
        else $error("store written outside data phase");
endmodule

>>> rtl/owpr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module owpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
